FILE: sv/multi_axis_bresenham_step_generator_unit_defines.svh
// assertion macros for the bresenham step generator checker
// depends on nothing, included by the checker file only
`ifndef MULTI_AXIS_BRESENHAM_STEP_GENERATOR_UNIT_DEFINES_SVH
`define MULTI_AXIS_BRESENHAM_STEP_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MABSG_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mabsg: same-cycle check failed");

// next-cycle implication
`define MABSG_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mabsg: next-cycle check failed");

`endif

FILE: sv/mabsg_pkg.sv
// shared types and constants of the bresenham step generator
// no dependencies, used by every rtl file by scoped name
package mabsg_pkg;

    localparam int AXIS_SLOTS = 4;
    localparam int AXES       = 4;
    localparam logic [AXIS_SLOTS-1:0] AXIS_MASK = AXIS_SLOTS'((1 << AXES) - 1);

    localparam int FUNC_W  = 2;
    localparam int DOM_W   = 24;
    localparam int DELTA_W = 24;
    localparam int ERR_W   = 32;
    localparam int STEPS_W = 16;
    localparam int DIR_W   = 4;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ABORT = 2'd2;

    // input word layout
    localparam int IN_DOM_LSB    = 0;
    localparam int IN_DELTA_LSB  = IN_DOM_LSB + DOM_W;
    localparam int IN_STEPS_LSB  = IN_DELTA_LSB + AXIS_SLOTS * DELTA_W;
    localparam int IN_DIR_LSB    = IN_STEPS_LSB + STEPS_W;
    localparam int IN_USED_W     = IN_DIR_LSB + DIR_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W    = FUNC_W;

    // output word layout
    localparam int OUT_STEP_LSB  = 0;
    localparam int OUT_DIR_LSB   = OUT_STEP_LSB + AXIS_SLOTS;
    localparam int OUT_BUSY_BIT  = OUT_DIR_LSB + DIR_W;
    localparam int OUT_USED_W    = OUT_BUSY_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_TICK  = 4'b0001,
        KIND_LOAD  = 4'b0010,
        KIND_ABORT = 4'b0100,
        KIND_NOP   = 4'b1000
    } kind_t;

    typedef struct packed {
        kind_t                                  kind;
        logic [ERR_W-1:0]                       err_init;
        logic [AXIS_SLOTS-1:0][DELTA_W-1:0]     delta;
        logic [AXIS_SLOTS-1:0][ERR_W-1:0]       dsub;
        logic [STEPS_W-1:0]                     target;
        logic [DIR_W-1:0]                       dir;
    } item_t;

    typedef struct packed {
        logic [AXIS_SLOTS-1:0] step;
        logic [DIR_W-1:0]      dir;
        logic                  done;
        logic                  busy;
    } result_t;

endpackage

FILE: sv/mabsg_front.sv
// front stage: takes input words, classifies them and precomputes load terms
// depends on mabsg_pkg
module mabsg_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dom_count, delta_x, delta_y, delta_z, delta_c, segment_steps, dir_bits
    input  logic [mabsg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [mabsg_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                push_valid,
    input  logic                                push_ready,
    output mabsg_pkg::item_t                    push_item
);

    logic                 vld_reg;
    logic                 vld_next;
    mabsg_pkg::item_t     item_reg;
    mabsg_pkg::item_t     item_next;
    logic [mabsg_pkg::DOM_W-1:0] dom;

    assign s_axis_tready = !vld_reg || push_ready;
    assign push_valid    = vld_reg;
    assign push_item     = item_reg;

    always_comb
    begin
        dom = s_axis_tdata[mabsg_pkg::IN_DOM_LSB +: mabsg_pkg::DOM_W];
        unique case (s_axis_tuser)
            mabsg_pkg::FUNC_TICK:  item_next.kind = mabsg_pkg::KIND_TICK;
            mabsg_pkg::FUNC_LOAD:  item_next.kind = mabsg_pkg::KIND_LOAD;
            mabsg_pkg::FUNC_ABORT: item_next.kind = mabsg_pkg::KIND_ABORT;
            default:               item_next.kind = mabsg_pkg::KIND_NOP;
        endcase
        // minus half the dominant count
        item_next.err_init = '0 - mabsg_pkg::ERR_W'(dom >> 1);
        for (int i = 0; i < mabsg_pkg::AXIS_SLOTS; i++)
        begin
            item_next.delta[i] = s_axis_tdata[mabsg_pkg::IN_DELTA_LSB + i * mabsg_pkg::DELTA_W
                                              +: mabsg_pkg::DELTA_W];
            item_next.dsub[i]  = mabsg_pkg::ERR_W'(item_next.delta[i])
                                 - mabsg_pkg::ERR_W'(dom);
        end
        item_next.target = s_axis_tdata[mabsg_pkg::IN_STEPS_LSB +: mabsg_pkg::STEPS_W];
        item_next.dir    = s_axis_tdata[mabsg_pkg::IN_DIR_LSB +: mabsg_pkg::DIR_W];
        vld_next = s_axis_tready ? s_axis_tvalid : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: sv/mabsg_queue.sv
// short queue between front and back stages
// depends on mabsg_pkg
module mabsg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mabsg_pkg::item_t    push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mabsg_pkg::item_t    pop_item
);

    mabsg_pkg::item_t                   slot_reg [mabsg_pkg::QUEUE_DEPTH];
    logic [mabsg_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [mabsg_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [mabsg_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [mabsg_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [mabsg_pkg::QUEUE_CW-1:0]     count_reg;
    logic [mabsg_pkg::QUEUE_CW-1:0]     count_next;
    logic                               do_push;
    logic                               do_pop;

    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop_valid && pop_ready;
    assign push_ready = (count_reg != mabsg_pkg::QUEUE_CW'(mabsg_pkg::QUEUE_DEPTH)) || do_pop;
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mabsg_pkg::QUEUE_AW'(mabsg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mabsg_pkg::QUEUE_AW'(mabsg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/mabsg_back.sv
// back stage: segment state, per-axis error update and output register
// depends on mabsg_pkg
module mabsg_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [mabsg_pkg::DIR_W-1:0]     cfg_data,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  mabsg_pkg::item_t                pop_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output mabsg_pkg::result_t              res
);

    logic [mabsg_pkg::DIR_W-1:0]                            inv_reg;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::ERR_W-1:0] err_reg;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::ERR_W-1:0] err_next;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::DELTA_W-1:0] delta_reg;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::DELTA_W-1:0] delta_next;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::ERR_W-1:0] dsub_reg;
    logic [mabsg_pkg::AXIS_SLOTS-1:0][mabsg_pkg::ERR_W-1:0] dsub_next;
    logic [mabsg_pkg::STEPS_W-1:0]  target_reg;
    logic [mabsg_pkg::STEPS_W-1:0]  target_next;
    logic [mabsg_pkg::STEPS_W-1:0]  taken_reg;
    logic [mabsg_pkg::STEPS_W-1:0]  taken_next;
    logic [mabsg_pkg::STEPS_W-1:0]  taken_inc;
    logic                           active_reg;
    logic                           active_next;
    logic [mabsg_pkg::DIR_W-1:0]    dir_reg;
    logic [mabsg_pkg::DIR_W-1:0]    dir_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    mabsg_pkg::result_t             out_reg;
    mabsg_pkg::result_t             out_next;
    logic [mabsg_pkg::ERR_W-1:0]    sum;
    logic [mabsg_pkg::ERR_W-1:0]    alt;
    logic                           pos;
    logic                           do_pop;

    assign pop_ready = !out_valid_reg || res_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        err_next      = err_reg;
        delta_next    = delta_reg;
        dsub_next     = dsub_reg;
        target_next   = target_reg;
        taken_next    = taken_reg;
        active_next   = active_reg;
        dir_next      = dir_reg;
        out_next.step = '0;
        out_next.done = 1'b0;
        taken_inc     = taken_reg + 1'b1;
        sum           = '0;
        alt           = '0;
        pos           = 1'b0;
        unique case (pop_item.kind)
            mabsg_pkg::KIND_LOAD:
            begin
                for (int i = 0; i < mabsg_pkg::AXIS_SLOTS; i++)
                begin
                    err_next[i] = pop_item.err_init;
                end
                delta_next  = pop_item.delta;
                dsub_next   = pop_item.dsub;
                target_next = pop_item.target;
                taken_next  = '0;
                active_next = 1'b1;
                dir_next    = (pop_item.dir ^ inv_reg) & mabsg_pkg::AXIS_MASK;
            end
            mabsg_pkg::KIND_ABORT:
            begin
                active_next = 1'b0;
                taken_next  = '0;
            end
            mabsg_pkg::KIND_TICK:
            begin
                if (active_reg)
                begin
                    for (int i = 0; i < mabsg_pkg::AXES; i++)
                    begin
                        // error plus delta, and the same with the dominant count taken off
                        sum = err_reg[i] + mabsg_pkg::ERR_W'(delta_reg[i]);
                        alt = err_reg[i] + dsub_reg[i];
                        pos = (sum != '0) && !sum[mabsg_pkg::ERR_W-1];
                        out_next.step[i] = pos;
                        err_next[i]      = pos ? alt : sum;
                    end
                    taken_next = taken_inc;
                    if (taken_inc >= target_reg)
                    begin
                        active_next   = 1'b0;
                        out_next.done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        out_next.dir   = dir_next;
        out_next.busy  = active_next;
        out_valid_next = do_pop ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= '0;
            err_reg       <= '0;
            delta_reg     <= '0;
            dsub_reg      <= '0;
            target_reg    <= '0;
            taken_reg     <= '0;
            active_reg    <= 1'b0;
            dir_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                inv_reg <= cfg_data;
            end
            if (do_pop)
            begin
                err_reg    <= err_next;
                delta_reg  <= delta_next;
                dsub_reg   <= dsub_next;
                target_reg <= target_next;
                taken_reg  <= taken_next;
                active_reg <= active_next;
                dir_reg    <= dir_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: sv/multi_axis_bresenham_step_generator_unit.sv
// four-axis bresenham step generator, top level
// depends on mabsg_pkg, mabsg_front, mabsg_queue and mabsg_back
//
// usage
// - input words on s_axis: tuser carries the function (tick, load, abort),
//   tdata the segment: dominant count, four deltas, step total, direction bits
// - every accepted word gives exactly one result word on m_axis: step mask and
//   direction levels in tdata, busy flag above them, tlast set on the tick that
//   ends a segment
// - cfg channel writes the direction invert mask; it is always ready and is
//   used by load words, so write it only while no word is in flight
// - one word per cycle sustained while m_axis accepts results; the result word
//   passes through the front register, two-word queue and output register
// - the per-tick error update is one add per axis with a precomputed
//   delta-minus-dominant term, so the back stage retires a word every cycle while m_axis is ready
// - when m_axis stalls the result holds, the queue fills and s_axis tready
//   drops once the front register and queue are full
// - reset clears the segment, errors, direction levels, invert mask and all
//   queued words
module multi_axis_bresenham_step_generator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dom_count, delta_x, delta_y, delta_z, delta_c, segment_steps, dir_bits
    input  logic [mabsg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [mabsg_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // step_mask, direction_levels, busy_res
    output logic [mabsg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mabsg_pkg::DIR_W-1:0]         cfg_data
);

    logic                   push_valid;
    logic                   push_ready;
    mabsg_pkg::item_t       push_item;
    logic                   pop_valid;
    logic                   pop_ready;
    mabsg_pkg::item_t       pop_item;
    mabsg_pkg::result_t     res;

    assign cfg_ready = 1'b1;

    mabsg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    mabsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mabsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[mabsg_pkg::OUT_STEP_LSB +: mabsg_pkg::AXIS_SLOTS] = res.step;
        m_axis_tdata[mabsg_pkg::OUT_DIR_LSB +: mabsg_pkg::DIR_W]       = res.dir;
        m_axis_tdata[mabsg_pkg::OUT_BUSY_BIT]                           = res.busy;
        m_axis_tlast = res.done;
    end

endmodule

FILE: sv/mabsg_checker.sv
// port-level checks on the step generator's result channel, bound to the top level
// depends on mabsg_pkg and the defines header
`include "multi_axis_bresenham_step_generator_unit_defines.svh"

module mabsg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [mabsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                 m_axis_tlast
);

    logic                               stalled;
    logic                               out_busy;
    logic                               idle_word;
    logic [mabsg_pkg::AXIS_SLOTS-1:0]   out_step;
    logic [mabsg_pkg::OUT_TDATA_W:0]    out_word;

    assign stalled   = m_axis_tvalid && !m_axis_tready;
    assign out_busy  = m_axis_tdata[mabsg_pkg::OUT_BUSY_BIT];
    assign out_step  = m_axis_tdata[mabsg_pkg::OUT_STEP_LSB +: mabsg_pkg::AXIS_SLOTS];
    assign out_word  = {m_axis_tlast, m_axis_tdata};
    assign idle_word = m_axis_tvalid && !m_axis_tlast && !out_busy;

    // a stalled result word holds
    `MABSG_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(out_word))

    // the tick that ends a segment leaves nothing active
    `MABSG_ASSERT_IMP(a_done_idle, clk, rst_n, m_axis_tvalid && m_axis_tlast, !out_busy)

    // no steps unless a segment was active for the tick
    `MABSG_ASSERT_IMP(a_idle_no_step, clk, rst_n, idle_word, out_step == '0)

endmodule

bind multi_axis_bresenham_step_generator_unit mabsg_checker u_mabsg_checker (.*);
